// ----- hw/rtl/rsm_pkg.sv -----
package rsm_pkg;

   // widths
   localparam int COUNT_WIDTH  = 16;
   localparam int TARGET_WIDTH = 11;
   localparam int STEP_WIDTH   = 8;
   localparam int CSR_AWIDTH   = 3;
   localparam int CSR_DWIDTH   = COUNT_WIDTH;
   localparam int REQ_DWIDTH   = 8;
   localparam int RSP_DWIDTH   = 32;

   // register reset values
   localparam logic [COUNT_WIDTH-1:0]  DEBOUNCE_RST    = COUNT_WIDTH'(300);
   localparam logic [COUNT_WIDTH-1:0]  INACTIVITY_RST  = COUNT_WIDTH'(10000);
   localparam logic [COUNT_WIDTH-1:0]  WELCOME_RST     = COUNT_WIDTH'(5000);
   localparam logic [TARGET_WIDTH-1:0] TARGET_MIN_RST  = TARGET_WIDTH'(400);
   localparam logic [TARGET_WIDTH-1:0] TARGET_MAX_RST  = TARGET_WIDTH'(1500);
   localparam logic [STEP_WIDTH-1:0]   TARGET_STEP_RST = STEP_WIDTH'(10);
   localparam logic [TARGET_WIDTH-1:0] INIT_TARGET_RST = TARGET_WIDTH'(500);

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_PRESS = 2'd1,
      ACT_STEP  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      SCR_WELCOME = 2'd0,
      SCR_IDLE    = 2'd1,
      SCR_MENU    = 2'd2,
      SCR_SET     = 2'd3
   } screen_type;

   typedef enum logic [CSR_AWIDTH-1:0] {
      CSR_DEBOUNCE    = 3'd0,
      CSR_INACTIVITY  = 3'd1,
      CSR_WELCOME     = 3'd2,
      CSR_TARGET_MIN  = 3'd3,
      CSR_TARGET_MAX  = 3'd4,
      CSR_TARGET_STEP = 3'd5,
      CSR_INIT_TARGET = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0]  debounce_ms;
      logic [COUNT_WIDTH-1:0]  inactivity_ms;
      logic [COUNT_WIDTH-1:0]  welcome_ms;
      logic [TARGET_WIDTH-1:0] target_min;
      logic [TARGET_WIDTH-1:0] target_max;
      logic [STEP_WIDTH-1:0]   target_step;
      logic                    init_load;
      logic [TARGET_WIDTH-1:0] initial_target;
   } cfg_type;

   typedef struct packed {
      logic [1:0] action;
      logic       phase_b;
   } item_type;

   typedef struct packed {
      screen_type              screen;
      logic                    menu_item;
      logic [TARGET_WIDTH-1:0] pending_target;
      logic [TARGET_WIDTH-1:0] saved_target;
      logic                    saved_now;
      logic                    event_taken;
   } result_type;

endpackage

// ----- hw/rtl/rsm_csr.sv -----
module rsm_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [rsm_pkg::CSR_AWIDTH-1:0] csr_addr,
   input  logic [rsm_pkg::CSR_DWIDTH-1:0] csr_wdata,
   output rsm_pkg::cfg_type              cfg
);
   import rsm_pkg::*;

   logic [COUNT_WIDTH-1:0]  debounce_ff,   debounce_in;
   logic [COUNT_WIDTH-1:0]  inactivity_ff, inactivity_in;
   logic [COUNT_WIDTH-1:0]  welcome_ff,    welcome_in;
   logic [TARGET_WIDTH-1:0] tmin_ff,       tmin_in;
   logic [TARGET_WIDTH-1:0] tmax_ff,       tmax_in;
   logic [STEP_WIDTH-1:0]   tstep_ff,      tstep_in;
   logic [TARGET_WIDTH-1:0] init_ff,       init_in;
   logic                    init_load;

   // register write decode
   always_comb begin
      debounce_in   = debounce_ff;
      inactivity_in = inactivity_ff;
      welcome_in    = welcome_ff;
      tmin_in       = tmin_ff;
      tmax_in       = tmax_ff;
      tstep_in      = tstep_ff;
      init_in       = init_ff;
      init_load     = 1'b0;
      if (csr_we) begin
         case (csr_addr)
            CSR_DEBOUNCE:    debounce_in   = csr_wdata[COUNT_WIDTH-1:0];
            CSR_INACTIVITY:  inactivity_in = csr_wdata[COUNT_WIDTH-1:0];
            CSR_WELCOME:     welcome_in    = csr_wdata[COUNT_WIDTH-1:0];
            CSR_TARGET_MIN:  tmin_in       = csr_wdata[TARGET_WIDTH-1:0];
            CSR_TARGET_MAX:  tmax_in       = csr_wdata[TARGET_WIDTH-1:0];
            CSR_TARGET_STEP: tstep_in      = csr_wdata[STEP_WIDTH-1:0];
            CSR_INIT_TARGET: begin
               init_in   = csr_wdata[TARGET_WIDTH-1:0];
               init_load = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RST;
         inactivity_ff <= INACTIVITY_RST;
         welcome_ff    <= WELCOME_RST;
         tmin_ff       <= TARGET_MIN_RST;
         tmax_ff       <= TARGET_MAX_RST;
         tstep_ff      <= TARGET_STEP_RST;
         init_ff       <= INIT_TARGET_RST;
      end else begin
         debounce_ff   <= debounce_in;
         inactivity_ff <= inactivity_in;
         welcome_ff    <= welcome_in;
         tmin_ff       <= tmin_in;
         tmax_ff       <= tmax_in;
         tstep_ff      <= tstep_in;
         init_ff       <= init_in;
      end
   end

   // the load pulse and its value go straight to the target registers
   assign cfg.debounce_ms    = debounce_ff;
   assign cfg.inactivity_ms  = inactivity_ff;
   assign cfg.welcome_ms     = welcome_ff;
   assign cfg.target_min     = tmin_ff;
   assign cfg.target_max     = tmax_ff;
   assign cfg.target_step    = tstep_ff;
   assign cfg.init_load      = init_load;
   assign cfg.initial_target = init_in;

endmodule

// ----- hw/rtl/rsm_core.sv -----
module rsm_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  rsm_pkg::item_type   item,
   input  rsm_pkg::cfg_type    cfg,
   output rsm_pkg::result_type result
);
   import rsm_pkg::*;

   screen_type              screen_ff,   screen_in;
   logic                    menu_ff,     menu_in;
   logic [TARGET_WIDTH-1:0] pending_ff,  pending_in;
   logic [TARGET_WIDTH-1:0] saved_ff,    saved_in;
   logic [COUNT_WIDTH-1:0]  press_ff,    press_in;
   logic [COUNT_WIDTH-1:0]  activity_ff, activity_in;
   logic [COUNT_WIDTH-1:0]  welcome_ff,  welcome_in;
   logic                    saved_now;
   logic                    event_taken;

   logic [COUNT_WIDTH-1:0]  press_inc;
   logic [COUNT_WIDTH-1:0]  activity_inc;
   logic [COUNT_WIDTH-1:0]  welcome_inc;
   logic [TARGET_WIDTH:0]   step_ext;
   logic [TARGET_WIDTH:0]   up_sum;
   logic [TARGET_WIDTH:0]   down_floor;
   logic [TARGET_WIDTH:0]   down_diff;
   logic                    press_ok;

   // saturating ms counters
   assign press_inc    = (press_ff == '1) ? press_ff : press_ff + COUNT_WIDTH'(1);
   assign activity_inc = (activity_ff == '1) ? activity_ff : activity_ff + COUNT_WIDTH'(1);
   assign welcome_inc  = (welcome_ff == '1) ? welcome_ff : welcome_ff + COUNT_WIDTH'(1);

   // one-bit-wider target arithmetic
   assign step_ext   = (TARGET_WIDTH+1)'(cfg.target_step);
   assign up_sum     = {1'b0, pending_ff} + step_ext;
   assign down_floor = {1'b0, cfg.target_min} + step_ext;
   assign down_diff  = {1'b0, pending_ff} - step_ext;
   assign press_ok   = (press_ff >= cfg.debounce_ms);

   // next state for one item
   always_comb begin
      screen_in   = screen_ff;
      menu_in     = menu_ff;
      pending_in  = pending_ff;
      saved_in    = saved_ff;
      press_in    = press_ff;
      activity_in = activity_ff;
      welcome_in  = welcome_ff;
      saved_now   = 1'b0;
      event_taken = 1'b0;
      case (item.action)
         ACT_TICK: begin
            press_in    = press_inc;
            activity_in = activity_inc;
            if (screen_ff == SCR_WELCOME) begin
               welcome_in = welcome_inc;
               if (welcome_inc > cfg.welcome_ms) begin
                  screen_in  = SCR_IDLE;
                  welcome_in = '0;
               end
            end else if (screen_ff == SCR_MENU || screen_ff == SCR_SET) begin
               if (activity_inc > cfg.inactivity_ms) screen_in = SCR_IDLE;
            end
         end
         ACT_PRESS: begin
            if (press_ok) begin
               event_taken = 1'b1;
               press_in    = '0;
               activity_in = '0;
               case (screen_ff)
                  SCR_WELCOME: begin
                     screen_in  = SCR_IDLE;
                     welcome_in = '0;
                  end
                  SCR_IDLE: screen_in = SCR_MENU;
                  SCR_MENU: screen_in = menu_ff ? SCR_IDLE : SCR_SET;
                  SCR_SET: begin
                     saved_in  = pending_ff;
                     saved_now = 1'b1;
                     screen_in = SCR_IDLE;
                  end
                  default: screen_in = SCR_IDLE;
               endcase
            end
         end
         ACT_STEP: begin
            event_taken = 1'b1;
            activity_in = '0;
            if (screen_ff == SCR_MENU) begin
               menu_in = ~menu_ff;
            end else if (screen_ff == SCR_SET) begin
               if (!item.phase_b) begin
                  // step up, clamp at max
                  if (pending_ff < cfg.target_max) begin
                     pending_in = (up_sum > {1'b0, cfg.target_max}) ?
                                  cfg.target_max : up_sum[TARGET_WIDTH-1:0];
                  end
               end else begin
                  // step down, clamp at min
                  if (pending_ff > cfg.target_min) begin
                     pending_in = ({1'b0, pending_ff} < down_floor) ?
                                  cfg.target_min : down_diff[TARGET_WIDTH-1:0];
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_ff   <= SCR_WELCOME;
         menu_ff     <= 1'b0;
         pending_ff  <= INIT_TARGET_RST;
         saved_ff    <= INIT_TARGET_RST;
         press_ff    <= '1;
         activity_ff <= '0;
         welcome_ff  <= '0;
      end else if (cfg.init_load) begin
         pending_ff <= cfg.initial_target;
         saved_ff   <= cfg.initial_target;
      end else if (fire) begin
         screen_ff   <= screen_in;
         menu_ff     <= menu_in;
         pending_ff  <= pending_in;
         saved_ff    <= saved_in;
         press_ff    <= press_in;
         activity_ff <= activity_in;
         welcome_ff  <= welcome_in;
      end
   end

   // result reflects the state after this item
   assign result.screen         = screen_in;
   assign result.menu_item      = menu_in;
   assign result.pending_target = pending_in;
   assign result.saved_target   = saved_in;
   assign result.saved_now      = saved_now;
   assign result.event_taken    = event_taken;

`ifndef SYNTHESIS
   a_step_clears_activity: assert property (@(posedge clock) disable iff (reset)
      fire && !cfg.init_load && item.action == ACT_STEP |=> activity_ff == '0)
      else $error("encoder step did not clear activity counter");

   a_save_copies_pending: assert property (@(posedge clock) disable iff (reset)
      fire && !cfg.init_load && saved_now |=> saved_ff == $past(pending_ff))
      else $error("save did not copy pending target");

   a_welcome_count_idle: assert property (@(posedge clock) disable iff (reset)
      screen_ff != SCR_WELCOME |-> welcome_ff == '0)
      else $error("welcome counter running off the welcome screen");

   a_bounce_dropped: assert property (@(posedge clock) disable iff (reset)
      fire && !cfg.init_load && item.action == ACT_PRESS && !press_ok
      |=> $stable(screen_ff) && $stable(saved_ff) && $stable(activity_ff))
      else $error("bounced press changed state");
`endif

endmodule

// ----- hw/rtl/rotary_encoder_setpoint_menu.sv -----
// Rotary encoder setpoint menu. Each request beat is a 1 ms tick, a button
// falling edge or a phase A rising edge with the phase B level; each one
// produces exactly one response beat with the screen, menu highlight,
// pending and saved targets and two event flags. The block takes one beat
// per clock while the response is accepted: a request register feeds the
// combinational state update into a response register; a stalled response
// holds at most one further beat in the request register. The user must
// write registers through the csr_ port only while no beat is in flight; the
// block does not enforce it. Writing initial_target also reloads the pending and saved targets.
module rotary_encoder_setpoint_menu (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [rsm_pkg::REQ_DWIDTH-1:0] req_tdata,  // action[1:0], phase_b[2]
   // response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // screen[1:0], menu_item[2], pending_target[13:3], saved_target[24:14],
   // saved_now[25], event_taken[26]
   output logic [rsm_pkg::RSP_DWIDTH-1:0] rsp_tdata,
   // register write port
   input  logic                           csr_we,
   input  logic [rsm_pkg::CSR_AWIDTH-1:0] csr_addr,
   input  logic [rsm_pkg::CSR_DWIDTH-1:0] csr_wdata
);
   import rsm_pkg::*;

   logic       in_valid_ff, in_valid_in;
   item_type   item_ff,     item_in;
   logic       out_valid_ff, out_valid_in;
   result_type result_ff,   result_in;
   logic       out_ready;
   logic       fire;
   cfg_type    cfg;

   // handshake: a beat moves on when the response slot is free or draining
   assign out_ready  = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_ready;
   assign req_tready = !in_valid_ff || out_ready;

   always_comb begin
      in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
      item_in      = item_ff;
      if (req_tready && req_tvalid) begin
         item_in.action  = req_tdata[1:0];
         item_in.phase_b = req_tdata[2];
      end
      out_valid_in = out_ready ? in_valid_ff : out_valid_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (fire) result_ff <= result_in;
   end

   rsm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rsm_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result_in)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0,
                        result_ff.event_taken,
                        result_ff.saved_now,
                        result_ff.saved_target,
                        result_ff.pending_target,
                        result_ff.menu_item,
                        result_ff.screen};

endmodule
